### src/flocking_alignment_step_core_defines.svh
// Assertion macros for the flocking alignment step RTL.
`ifndef FLOCKING_ALIGNMENT_STEP_CORE_DEFINES_SVH
`define FLOCKING_ALIGNMENT_STEP_CORE_DEFINES_SVH
`ifndef NO_ASSERTIONS
// checked only out of reset
`define FAS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("fas assertion failed");
// checked at every edge, reset included
`define FAS_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("fas assertion failed");
`else
`define FAS_ASSERT(lbl, prop)
`define FAS_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

### src/fas_pkg.sv
// Package: types, codes and constants of the flocking alignment step core.
`default_nettype none
package fas_pkg;

  // item functions
  typedef enum logic [1:0] {
    FN_LOAD  = 2'd0,
    FN_MOVE  = 2'd1,
    FN_ALIGN = 2'd2,
    FN_PEEK  = 2'd3
  } fas_func_t;

  // configuration register indexes
  localparam logic [2:0] CFG_BOX   = 3'd0;
  localparam logic [2:0] CFG_SPD_E = 3'd1;
  localparam logic [2:0] CFG_SPD_O = 3'd2;
  localparam logic [2:0] CFG_RAD   = 3'd3;
  localparam logic [2:0] CFG_GAIN  = 3'd4;

  localparam logic [15:0] BOX_RST   = 16'd20480;
  localparam logic [14:0] SPD_E_RST = 15'd410;
  localparam logic [14:0] SPD_O_RST = 15'd205;
  localparam logic [15:0] RAD_RST   = 16'd4096;
  localparam logic [15:0] GAIN_RST  = 16'd20861;

  // CORDIC gain compensation, 2^16 scale
  localparam logic [15:0] CORDIC_K = 16'd39797;
  localparam int          ZW       = 26;

  typedef enum logic [3:0] {
    S_IDLE, S_MV_RD, S_MV_INIT, S_MV_RUN, S_MV_RND, S_MV_SAT, S_MV_WB,
    S_AL_RD, S_AL_SELF, S_AL_WALK, S_AL_DRAIN, S_AL_VEC, S_AL_RUN, S_AL_FIN,
    S_RP_RD, S_RP_OUT
  } fas_state_t;

  // one particle record
  typedef struct packed {
    logic [15:0] px;
    logic [15:0] py;
    logic [15:0] hd;
    logic [15:0] vx;
    logic [15:0] vy;
  } fas_rec_t;

  // store write enables
  typedef struct packed {
    logic pos;
    logic hd;
    logic vel;
  } fas_wr_t;

  // CORDIC command
  typedef struct packed {
    logic start;
    logic vec;
  } fas_ccmd_t;

  // atan(2^-i) at 2^24 per turn
  function automatic logic [21:0] fas_atan(input logic [3:0] i);
    logic [21:0] a;
    case (i)
      4'd0:  a = 22'd2097152;
      4'd1:  a = 22'd1238021;
      4'd2:  a = 22'd654136;
      4'd3:  a = 22'd332050;
      4'd4:  a = 22'd166669;
      4'd5:  a = 22'd83416;
      4'd6:  a = 22'd41718;
      4'd7:  a = 22'd20860;
      4'd8:  a = 22'd10430;
      4'd9:  a = 22'd5215;
      4'd10: a = 22'd2608;
      4'd11: a = 22'd1304;
      4'd12: a = 22'd652;
      4'd13: a = 22'd326;
      4'd14: a = 22'd163;
      4'd15: a = 22'd81;
      default: a = 22'd0;
    endcase
    return a;
  endfunction

endpackage
`default_nettype wire

### src/flocking_alignment_step_core.sv
// Top level of the flocking alignment step core: sequencer and datapath.
//
//  channel | ports                                         | transaction at
//  input   | start, busy, in_func .. in_random_draw        | start & !busy
//  result  | out_valid, out_particle .. out_heading        | out_valid
//  config  | cfg_we, cfg_index, cfg_data                   | cfg_we
//
// Load and out-of-range items: no busy cycles, result one cycle after the transaction.
// Peek: busy through the store read (S_RP_RD) and S_RP_OUT, then the result.
// Move: store read, CORDIC start, CORDIC wait, rounding, saturation, write-back.
// Align: one store read per particle, then the vectoring CORDIC (skipped on a zero
// sum); the result follows S_AL_FIN in the next cycle.
// Reset clears control and loads the configuration defaults; the store is undefined until written.
// The result is a one-cycle strobe; the receiver cannot stall.
`default_nettype none
`include "flocking_alignment_step_core_defines.svh"
module flocking_alignment_step_core
  import fas_pkg::*;
#(
  parameter int PARTICLES = 512
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [1:0]         in_func,
  input  wire logic [8:0]         in_particle,
  input  wire logic [15:0]        in_load_x,
  input  wire logic [15:0]        in_load_y,
  input  wire logic signed [15:0] in_load_heading,
  input  wire logic [15:0]        in_random_draw,
  output logic                    out_valid,
  output logic [8:0]              out_particle,
  output logic [15:0]             out_x,
  output logic [15:0]             out_y,
  output logic signed [15:0]      out_heading,
  input  wire logic               cfg_we,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [15:0]        cfg_data
);

  localparam int AW    = (PARTICLES > 1) ? $clog2(PARTICLES) : 1;
  localparam int SUM_W = 16 + AW + 1;
  localparam int CW    = SUM_W + 19;
  localparam logic [AW-1:0] LAST = AW'(PARTICLES - 1);

  // configuration registers
  logic [15:0] box_r, rad_r, gain_r;
  logic [14:0] spd_e_r, spd_o_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      box_r   <= BOX_RST;
      spd_e_r <= SPD_E_RST;
      spd_o_r <= SPD_O_RST;
      rad_r   <= RAD_RST;
      gain_r  <= GAIN_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BOX:   box_r   <= cfg_data;
        CFG_SPD_E: spd_e_r <= cfg_data[14:0];
        CFG_SPD_O: spd_o_r <= cfg_data[14:0];
        CFG_RAD:   rad_r   <= cfg_data;
        CFG_GAIN:  gain_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  fas_state_t state_r, state_nxt;
  fas_func_t  func_in;
  logic       accept, idx_ok;
  logic [AW-1:0] in_addr;

  assign func_in = fas_func_t'(in_func);
  assign busy    = (state_r != S_IDLE);
  assign accept  = start && !busy;
  assign idx_ok  = (32'(in_particle) < 32'(PARTICLES));
  assign in_addr = AW'(in_particle);

  // store and CORDIC
  fas_wr_t       st_wr;
  logic [AW-1:0] st_waddr, st_raddr;
  fas_rec_t      st_wdata, rd_q;

  fas_store #(.DEPTH(PARTICLES), .AW(AW)) u_store (
    .clk     (clk),
    .wr      (st_wr),
    .wr_addr (st_waddr),
    .wr_data (st_wdata),
    .rd_addr (st_raddr),
    .rd_q    (rd_q)
  );

  fas_ccmd_t            ccmd;
  logic signed [CW-1:0] c_x0, c_y0, c_x, c_y;
  logic signed [ZW-1:0] c_z0, c_z;
  logic                 c_done;

  fas_cordic #(.W(CW)) u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (ccmd),
    .x0    (c_x0),
    .y0    (c_y0),
    .z0    (c_z0),
    .done  (c_done),
    .x     (c_x),
    .y     (c_y),
    .z     (c_z)
  );

  // item registers
  logic [8:0]           pidx_r;
  logic [AW-1:0]        p_r;
  logic [30:0]          spd_prod_r;
  logic signed [33:0]   noise_r;
  logic [31:0]          r2_r;
  logic [15:0]          px_r, py_r, hd_r;
  logic                 flip_r, zero_r;
  logic [CW-17:0]       rx_r, ry_r;
  logic                 nx_r, ny_r;
  logic [15:0]          vx_r, vy_r;
  logic [AW-1:0]        walk_r;
  logic                 v1_r, self1_r, v2_r, self2_r;
  logic [31:0]          sqx_r, sqy_r;
  logic [15:0]          vx2_r, vy2_r;
  logic signed [SUM_W-1:0] sumx_r, sumy_r;
  logic                 out_valid_r;
  logic [8:0]           opart_r;
  logic [15:0]          ox_r, oy_r, ohd_r;

  // heading fold for the move rotation
  logic signed [15:0] h_in, h_fold;
  logic               fold;
  always_comb begin
    h_in = signed'(rd_q.hd);
    fold = 1'b0;
    h_fold = h_in;
    if (h_in > 16'sd16384) begin
      h_fold = h_in - 16'sd32768;
      fold   = 1'b1;
    end else if (h_in < -16'sd16384) begin
      h_fold = h_in + 16'sd32768;
      fold   = 1'b1;
    end
  end

  // position wrap after the move
  logic signed [17:0] sx_sum, sy_sum, sx_w, sy_w, box_s;
  always_comb begin
    box_s  = signed'({2'b00, box_r});
    sx_sum = signed'({2'b00, px_r}) + 18'(signed'(vx_r));
    sy_sum = signed'({2'b00, py_r}) + 18'(signed'(vy_r));
    sx_w = sx_sum;
    sy_w = sy_sum;
    if (sx_sum < 0) sx_w = sx_sum + box_s;
    else if (sx_sum > box_s) sx_w = sx_sum - box_s;
    if (sy_sum < 0) sy_w = sy_sum + box_s;
    else if (sy_sum > box_s) sy_w = sy_sum - box_s;
  end

  // heading after align: angle * 256 + noise, rounded at 2^16 per turn
  logic [33:0] total;
  logic [15:0] hd_new;
  always_comb begin
    total  = (zero_r ? 34'd0 : {c_z, 8'd0}) + noise_r + 34'd32768;
    hd_new = total[31:16];
  end

  // rounding magnitudes and saturation
  logic [CW-1:0]   ax, ay;
  logic [CW-17:0]  rxn, ryn;
  logic [15:0]     sat_x, sat_y;
  always_comb begin
    ax  = c_x[CW-1] ? CW'(-c_x) : CW'(c_x);
    ay  = c_y[CW-1] ? CW'(-c_y) : CW'(c_y);
    rxn = (CW-16)'((ax + CW'(32768)) >> 16);
    ryn = (CW-16)'((ay + CW'(32768)) >> 16);
    if (!nx_r) sat_x = (rx_r > (CW-16)'(32767)) ? 16'h7FFF : rx_r[15:0];
    else       sat_x = (rx_r > (CW-16)'(32768)) ? 16'h8000 : 16'(-rx_r[15:0]);
    if (!ny_r) sat_y = (ry_r > (CW-16)'(32767)) ? 16'h7FFF : ry_r[15:0];
    else       sat_y = (ry_r > (CW-16)'(32768)) ? 16'h8000 : 16'(-ry_r[15:0]);
  end

  // sequencer: next state, store and CORDIC controls
  logic issue, out_fire;
  always_comb begin
    state_nxt = state_r;
    st_wr     = '0;
    st_waddr  = p_r;
    st_wdata  = '0;
    st_raddr  = p_r;
    ccmd      = '0;
    c_x0      = '0;
    c_y0      = '0;
    c_z0      = '0;
    issue     = 1'b0;
    out_fire  = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (!idx_ok) begin
            out_fire = 1'b1;
          end else begin
            case (func_in)
              FN_LOAD: begin
                st_wr    = '{pos: 1'b1, hd: 1'b1, vel: 1'b1};
                st_waddr = in_addr;
                st_wdata = '{px: in_load_x, py: in_load_y, hd: in_load_heading,
                             vx: 16'd0, vy: 16'd0};
                out_fire = 1'b1;
              end
              FN_MOVE:  state_nxt = S_MV_RD;
              FN_ALIGN: state_nxt = S_AL_RD;
              FN_PEEK:  state_nxt = S_RP_RD;
              default: ;
            endcase
          end
        end
      end
      S_MV_RD:   state_nxt = S_MV_INIT;
      S_MV_INIT: begin
        ccmd.start = 1'b1;
        c_x0       = CW'(signed'({1'b0, spd_prod_r}));
        c_z0       = signed'({{2{h_fold[15]}}, h_fold, 8'd0});
        state_nxt  = S_MV_RUN;
      end
      S_MV_RUN:  if (c_done) state_nxt = S_MV_RND;
      S_MV_RND:  state_nxt = S_MV_SAT;
      S_MV_SAT:  state_nxt = S_MV_WB;
      S_MV_WB: begin
        st_wr    = '{pos: 1'b1, hd: 1'b0, vel: 1'b1};
        st_wdata = '{px: sx_w[15:0], py: sy_w[15:0], hd: hd_r, vx: vx_r, vy: vy_r};
        out_fire = 1'b1;
        state_nxt = S_IDLE;
      end
      S_AL_RD:   state_nxt = S_AL_SELF;
      S_AL_SELF: state_nxt = S_AL_WALK;
      S_AL_WALK: begin
        st_raddr = walk_r;
        issue    = 1'b1;
        if (walk_r == LAST) state_nxt = S_AL_DRAIN;
      end
      S_AL_DRAIN: if (!v1_r && !v2_r) state_nxt = S_AL_VEC;
      S_AL_VEC: begin
        if (sumx_r == '0 && sumy_r == '0) begin
          state_nxt = S_AL_FIN;
        end else begin
          ccmd.start = 1'b1;
          ccmd.vec   = 1'b1;
          if (sumx_r[SUM_W-1]) begin
            c_x0 = CW'(-sumx_r) <<< 16;
            c_y0 = CW'(-sumy_r) <<< 16;
            c_z0 = ZW'(24'd8388608);
          end else begin
            c_x0 = CW'(sumx_r) <<< 16;
            c_y0 = CW'(sumy_r) <<< 16;
          end
          state_nxt = S_AL_RUN;
        end
      end
      S_AL_RUN: if (c_done) state_nxt = S_AL_FIN;
      S_AL_FIN: begin
        st_wr     = '{pos: 1'b0, hd: 1'b1, vel: 1'b0};
        st_wdata  = '{px: px_r, py: py_r, hd: hd_new, vx: 16'd0, vy: 16'd0};
        out_fire  = 1'b1;
        state_nxt = S_IDLE;
      end
      S_RP_RD:  state_nxt = S_RP_OUT;
      S_RP_OUT: begin
        out_fire  = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_fire;
      v1_r        <= issue;
      v2_r        <= v1_r;
    end
  end

  // datapath registers
  logic signed [16:0] dx, dy;
  logic signed [33:0] dx2, dy2;
  assign dx  = signed'({1'b0, rd_q.px}) - signed'({1'b0, px_r});
  assign dy  = signed'({1'b0, rd_q.py}) - signed'({1'b0, py_r});
  assign dx2 = dx * dx;
  assign dy2 = dy * dy;

  always_ff @(posedge clk) begin
    // item capture
    if (accept) begin
      pidx_r     <= in_particle;
      p_r        <= in_addr;
      spd_prod_r <= {16'd0, (in_particle[0] ? spd_o_r : spd_e_r)} * {15'd0, CORDIC_K};
      noise_r    <= signed'({1'b0, gain_r}) *
                    (signed'({1'b0, in_random_draw}) - 17'sd32768);
      r2_r       <= rad_r * rad_r;
    end
    // fetched record (move and align) and move rounding
    if (state_r == S_MV_INIT || state_r == S_AL_SELF) begin
      px_r <= rd_q.px;
      py_r <= rd_q.py;
      hd_r <= rd_q.hd;
    end
    if (state_r == S_MV_INIT) flip_r <= fold;
    if (state_r == S_MV_RND) begin
      rx_r <= rxn;
      ry_r <= ryn;
      nx_r <= c_x[CW-1] ^ flip_r;
      ny_r <= c_y[CW-1] ^ flip_r;
    end
    if (state_r == S_MV_SAT) begin
      vx_r <= sat_x;
      vy_r <= sat_y;
    end
    // align walk: read, square, accumulate
    if (state_r == S_AL_SELF) begin
      walk_r <= '0;
      sumx_r <= '0;
      sumy_r <= '0;
    end else if (issue) begin
      walk_r <= walk_r + AW'(1);
    end
    self1_r <= (walk_r == p_r);
    self2_r <= self1_r;
    sqx_r   <= dx2[31:0];
    sqy_r   <= dy2[31:0];
    vx2_r   <= rd_q.vx;
    vy2_r   <= rd_q.vy;
    if (v2_r && (self2_r || ({1'b0, sqx_r} + {1'b0, sqy_r} < {1'b0, r2_r}))) begin
      sumx_r <= sumx_r + SUM_W'(signed'(vx2_r));
      sumy_r <= sumy_r + SUM_W'(signed'(vy2_r));
    end
    if (state_r == S_AL_VEC) zero_r <= (sumx_r == '0 && sumy_r == '0);
    // result registers
    if (out_fire) begin
      opart_r <= (state_r == S_IDLE) ? in_particle : pidx_r;
      case (state_r)
        S_IDLE: begin
          ox_r  <= idx_ok ? in_load_x : 16'd0;
          oy_r  <= idx_ok ? in_load_y : 16'd0;
          ohd_r <= idx_ok ? in_load_heading : 16'd0;
        end
        S_MV_WB: begin
          ox_r  <= sx_w[15:0];
          oy_r  <= sy_w[15:0];
          ohd_r <= hd_r;
        end
        S_AL_FIN: begin
          ox_r  <= px_r;
          oy_r  <= py_r;
          ohd_r <= hd_new;
        end
        default: begin
          ox_r  <= rd_q.px;
          oy_r  <= rd_q.py;
          ohd_r <= rd_q.hd;
        end
      endcase
    end
  end

  assign out_valid    = out_valid_r;
  assign out_particle = opart_r;
  assign out_x        = ox_r;
  assign out_y        = oy_r;
  assign out_heading  = ohd_r;

  // checks
  `FAS_ASSERT_ALWAYS(a_rst_quiet, !rst_n |=> !out_valid && !busy)
  `FAS_ASSERT(a_walk_step, (state_r == S_AL_WALK && walk_r != LAST) |=> walk_r == $past(walk_r) + AW'(1))
  `FAS_ASSERT(a_cordic_busy, c_done |-> (state_r == S_MV_RUN || state_r == S_AL_RUN))
  `FAS_ASSERT(a_out_cause, out_valid |-> $past(busy) || $past(start))

endmodule
`default_nettype wire

### src/fas_store.sv
// Particle store: five field memories, one write and one registered read port.
`default_nettype none
module fas_store
  import fas_pkg::*;
#(
  parameter int DEPTH = 512,
  parameter int AW    = 9
) (
  input  wire logic          clk,
  input  wire fas_wr_t       wr,
  input  wire logic [AW-1:0] wr_addr,
  input  wire fas_rec_t      wr_data,
  input  wire logic [AW-1:0] rd_addr,
  output fas_rec_t           rd_q
);

  logic [15:0] px_mem [DEPTH];
  logic [15:0] py_mem [DEPTH];
  logic [15:0] hd_mem [DEPTH];
  logic [15:0] vx_mem [DEPTH];
  logic [15:0] vy_mem [DEPTH];

  // write side
  always_ff @(posedge clk) begin
    if (wr.pos) begin
      px_mem[wr_addr] <= wr_data.px;
      py_mem[wr_addr] <= wr_data.py;
    end
    if (wr.hd) begin
      hd_mem[wr_addr] <= wr_data.hd;
    end
    if (wr.vel) begin
      vx_mem[wr_addr] <= wr_data.vx;
      vy_mem[wr_addr] <= wr_data.vy;
    end
  end

  // read side, registered
  always_ff @(posedge clk) begin
    rd_q.px <= px_mem[rd_addr];
    rd_q.py <= py_mem[rd_addr];
    rd_q.hd <= hd_mem[rd_addr];
    rd_q.vx <= vx_mem[rd_addr];
    rd_q.vy <= vy_mem[rd_addr];
  end

endmodule
`default_nettype wire

### src/fas_cordic.sv
// Iterative CORDIC, rotation or vectoring, one micro-rotation per cycle.
`default_nettype none
module fas_cordic
  import fas_pkg::*;
#(
  parameter int W = 37
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire fas_ccmd_t           cmd,
  input  wire logic signed [W-1:0] x0,
  input  wire logic signed [W-1:0] y0,
  input  wire logic signed [ZW-1:0] z0,
  output logic                     done,
  output logic signed [W-1:0]      x,
  output logic signed [W-1:0]      y,
  output logic signed [ZW-1:0]     z
);

  logic signed [W-1:0]  x_r, y_r;
  logic signed [ZW-1:0] z_r;
  logic [3:0]           it_r;
  logic                 run_r, vec_r, done_r;
  logic                 dir_pos;
  logic signed [W-1:0]  xs, ys;
  logic signed [ZW-1:0] at;

  // direction and shifted terms of this step
  always_comb begin
    dir_pos = vec_r ? y_r[W-1] : !z_r[ZW-1];
    xs      = x_r >>> it_r;
    ys      = y_r >>> it_r;
    at      = ZW'(fas_atan(it_r));
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      it_r   <= '0;
    end else begin
      done_r <= 1'b0;
      if (cmd.start) begin
        run_r <= 1'b1;
        it_r  <= '0;
      end else if (run_r) begin
        it_r <= it_r + 4'd1;
        if (it_r == 4'd15) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      x_r   <= x0;
      y_r   <= y0;
      z_r   <= z0;
      vec_r <= cmd.vec;
    end else if (run_r) begin
      if (dir_pos) begin
        x_r <= x_r - ys;
        y_r <= y_r + xs;
        z_r <= z_r - at;
      end else begin
        x_r <= x_r + ys;
        y_r <= y_r - xs;
        z_r <= z_r + at;
      end
    end
  end

  assign done = done_r;
  assign x    = x_r;
  assign y    = y_r;
  assign z    = z_r;

endmodule
`default_nettype wire
